// ===== hdl/assert_macros.svh =====
// Assertion helpers for the RTL files, included by key_value_table.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Check a property on every rising edge outside reset.
`define KVT_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("property violated");

// Check that a condition never holds outside reset.
`define KVT_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("forbidden condition seen");

`else

`define KVT_ASSERT(lbl, clk, rst_n, prop)
`define KVT_NEVER(lbl, clk, rst_n, cond)

`endif

`endif

// ===== hdl/kvt_pkg.sv =====
package kvt_pkg;

    localparam int DEPTH_DEFAULT = 16;

    localparam int KEY_W   = 32;
    localparam int VALUE_W = 32;
    localparam int KIND_W  = 2;
    localparam int STAT_W  = 3;
    localparam int COUNT_W = 5;

    // operation codes
    localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
    localparam logic [KIND_W-1:0] KIND_REMOVE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_LOOKUP = 2'd2;

    // result codes
    localparam logic [STAT_W-1:0] STAT_INSERTED  = 3'd0;
    localparam logic [STAT_W-1:0] STAT_UPDATED   = 3'd1;
    localparam logic [STAT_W-1:0] STAT_REMOVED   = 3'd2;
    localparam logic [STAT_W-1:0] STAT_NOT_FOUND = 3'd3;
    localparam logic [STAT_W-1:0] STAT_FOUND     = 3'd4;
    localparam logic [STAT_W-1:0] STAT_FULL      = 3'd5;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_FINISH
    } t_state;

    // scan outcome reported by the store
    typedef struct packed {
        logic hit;
        logic free;
    } t_probe;

    // write-back command to the store
    typedef struct packed {
        logic wr_key;
        logic wr_value;
        logic set_valid;
        logic clr_valid;
    } t_wr_ctl;

endpackage

// ===== hdl/kvt_store.sv =====
module kvt_store #(
    parameter int DEPTH = kvt_pkg::DEPTH_DEFAULT,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_clear,
    input  logic                       i_rd_en,
    input  logic [AW-1:0]              i_rd_addr,
    input  logic [kvt_pkg::KEY_W-1:0]  i_key,
    output kvt_pkg::t_probe            o_probe,
    output logic [AW-1:0]              o_hit_idx,
    output logic [AW-1:0]              o_free_idx,
    output logic [kvt_pkg::VALUE_W-1:0] o_hit_value,
    input  kvt_pkg::t_wr_ctl           i_wr,
    input  logic [AW-1:0]              i_wr_idx,
    input  logic [kvt_pkg::KEY_W-1:0]  i_wr_key,
    input  logic [kvt_pkg::VALUE_W-1:0] i_wr_value
);

    logic [kvt_pkg::KEY_W-1:0]   r_key_mem [DEPTH];
    logic [kvt_pkg::VALUE_W-1:0] r_val_mem [DEPTH];
    logic [DEPTH-1:0]            r_valid;

    logic [kvt_pkg::KEY_W-1:0]   r_key_q;
    logic [kvt_pkg::VALUE_W-1:0] r_val_q;
    logic                        r_rd_pend;
    logic [AW-1:0]               r_rd_idx;

    logic                        r_hit;
    logic                        r_free;
    logic [AW-1:0]               r_hit_idx;
    logic [AW-1:0]               r_free_idx;
    logic [kvt_pkg::VALUE_W-1:0] r_hit_value;

    logic                        cmp_valid;
    logic                        cmp_match;

    always_ff @(posedge i_clk) begin
        if (i_wr.wr_key) begin
            r_key_mem[i_wr_idx] <= i_wr_key;
        end
        if (i_rd_en) begin
            r_key_q <= r_key_mem[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.wr_value) begin
            r_val_mem[i_wr_idx] <= i_wr_value;
        end
        if (i_rd_en) begin
            r_val_q <= r_val_mem[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_wr.set_valid) begin
            r_valid[i_wr_idx] <= 1'b1;
        end else if (i_wr.clr_valid) begin
            r_valid[i_wr_idx] <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_pend <= 1'b0;
        end else begin
            r_rd_pend <= i_rd_en;
        end
        r_rd_idx <= i_rd_addr;
    end

    // entries without a valid mark never match, whatever the memory holds
    assign cmp_valid = r_valid[r_rd_idx];
    assign cmp_match = cmp_valid && (r_key_q == i_key);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_hit  <= 1'b0;
            r_free <= 1'b0;
        end else if (r_rd_pend) begin
            if (cmp_match) begin
                r_hit <= 1'b1;
            end
            // keep the lowest free slot
            if (!cmp_valid && !r_free) begin
                r_free <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_rd_pend && cmp_match) begin
            r_hit_idx   <= r_rd_idx;
            r_hit_value <= r_val_q;
        end
        if (r_rd_pend && !cmp_valid && !r_free) begin
            r_free_idx <= r_rd_idx;
        end
    end

    assign o_probe.hit  = r_hit;
    assign o_probe.free = r_free;
    assign o_hit_idx    = r_hit_idx;
    assign o_free_idx   = r_free_idx;
    assign o_hit_value  = r_hit_value;

endmodule

// ===== hdl/key_value_table.sv =====
// key_value_table: associative store of up to DEPTH key/value pairs.
// Slave channel: one word per operation; tuser carries the operation code
// (insert or update, remove, lookup), tdata carries key and value.
// Master channel: one word per operation; tuser carries the status code,
// tdata the looked-up value (zero unless found) and the entry count.
// Each operation walks the key and value memories one entry per cycle,
// then decides and writes back in the same cycle. An accepted word is
// walked in the scan state, its last read is compared in the drain state
// and its result goes to the output register in the finish state; only
// then is a new word taken. The memories have a single read port.
// The result sits in an output register: the next word is accepted while
// it waits. If the receiver stalls, the following operation finishes its
// walk and then holds until the output register is free.
// Reset clears the valid marks and the entry count at once; memory
// contents are not cleared and are never used without a valid mark.
// Keys are matched as exact 32-bit patterns.
module key_value_table #(
    parameter int DEPTH = kvt_pkg::DEPTH_DEFAULT
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [63:0] i_s_tdata,   // [31:0] entry_key, [63:32] entry_value
    input  logic [1:0]  i_s_tuser,   // [1:0] kind
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [39:0] o_m_tdata,   // [31:0] found_value, [36:32] entry_count
    output logic [2:0]  o_m_tuser    // [2:0] status
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    kvt_pkg::t_state r_state, n_state;

    logic [kvt_pkg::KIND_W-1:0]  r_kind;
    logic [kvt_pkg::KEY_W-1:0]   r_key;
    logic [kvt_pkg::VALUE_W-1:0] r_value;
    logic [AW-1:0]               r_addr;
    logic [CW-1:0]               r_count, n_count;

    logic                         r_out_valid;
    logic [kvt_pkg::STAT_W-1:0]   r_out_status;
    logic [kvt_pkg::VALUE_W-1:0]  r_out_value;
    logic [kvt_pkg::COUNT_W-1:0]  r_out_count;

    logic                         accept;
    logic                         rd_en;
    logic                         commit;
    logic                         last_addr;

    kvt_pkg::t_probe              probe;
    logic [AW-1:0]                hit_idx;
    logic [AW-1:0]                free_idx;
    logic [kvt_pkg::VALUE_W-1:0]  hit_value;

    kvt_pkg::t_wr_ctl             wr_op;
    kvt_pkg::t_wr_ctl             wr;
    logic [AW-1:0]                wr_idx;
    logic [kvt_pkg::STAT_W-1:0]   res_status;
    logic [kvt_pkg::VALUE_W-1:0]  res_value;
    logic [CW+kvt_pkg::COUNT_W-1:0] count_ext;

    assign accept    = i_s_tvalid && o_s_tready;
    assign last_addr = (r_addr == AW'(DEPTH - 1));

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            kvt_pkg::ST_IDLE: begin
                if (i_s_tvalid) n_state = kvt_pkg::ST_SCAN;
            end
            kvt_pkg::ST_SCAN: begin
                if (last_addr) n_state = kvt_pkg::ST_DRAIN;
            end
            kvt_pkg::ST_DRAIN: begin
                n_state = kvt_pkg::ST_FINISH;
            end
            kvt_pkg::ST_FINISH: begin
                if (!r_out_valid || i_m_tready) n_state = kvt_pkg::ST_IDLE;
            end
            default: n_state = kvt_pkg::ST_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        o_s_tready = 1'b0;
        rd_en      = 1'b0;
        commit     = 1'b0;
        unique case (r_state)
            kvt_pkg::ST_IDLE:   o_s_tready = 1'b1;
            kvt_pkg::ST_SCAN:   rd_en = 1'b1;
            kvt_pkg::ST_DRAIN:  ;
            kvt_pkg::ST_FINISH: commit = !r_out_valid || i_m_tready;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= kvt_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_kind  <= i_s_tuser;
            r_key   <= i_s_tdata[31:0];
            r_value <= i_s_tdata[63:32];
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_addr <= '0;
        end else if (rd_en) begin
            r_addr <= r_addr + 1'b1;
        end
    end

    // decide the operation from the finished walk
    always_comb begin
        wr_op      = '0;
        wr_idx     = probe.hit ? hit_idx : free_idx;
        res_status = kvt_pkg::STAT_NOT_FOUND;
        res_value  = '0;
        n_count    = r_count;
        unique case (r_kind)
            kvt_pkg::KIND_INSERT: begin
                if (probe.hit) begin
                    wr_op.wr_value = 1'b1;
                    res_status     = kvt_pkg::STAT_UPDATED;
                end else if (probe.free) begin
                    wr_op.wr_key    = 1'b1;
                    wr_op.wr_value  = 1'b1;
                    wr_op.set_valid = 1'b1;
                    n_count         = r_count + 1'b1;
                    res_status      = kvt_pkg::STAT_INSERTED;
                end else begin
                    res_status = kvt_pkg::STAT_FULL;
                end
            end
            kvt_pkg::KIND_REMOVE: begin
                if (probe.hit) begin
                    wr_op.clr_valid = 1'b1;
                    n_count         = r_count - 1'b1;
                    res_status      = kvt_pkg::STAT_REMOVED;
                end
            end
            kvt_pkg::KIND_LOOKUP: begin
                if (probe.hit) begin
                    res_value  = hit_value;
                    res_status = kvt_pkg::STAT_FOUND;
                end
            end
            default: ;
        endcase
    end

    assign wr        = commit ? wr_op : '0;
    assign count_ext = {{kvt_pkg::COUNT_W{1'b0}}, n_count};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (commit) begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (commit) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (commit) begin
            r_out_status <= res_status;
            r_out_value  <= res_value;
            r_out_count  <= count_ext[kvt_pkg::COUNT_W-1:0];
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_out_status;
    assign o_m_tdata  = {3'b000, r_out_count, r_out_value};

    kvt_store #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_store (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_clear     (accept),
        .i_rd_en     (rd_en),
        .i_rd_addr   (r_addr),
        .i_key       (r_key),
        .o_probe     (probe),
        .o_hit_idx   (hit_idx),
        .o_free_idx  (free_idx),
        .o_hit_value (hit_value),
        .i_wr        (wr),
        .i_wr_idx    (wr_idx),
        .i_wr_key    (r_key),
        .i_wr_value  (r_value)
    );

`include "assert_macros.svh"

    `KVT_NEVER(a_count_bound, i_clk, i_rst_n, r_count > CW'(DEPTH))
    `KVT_ASSERT(a_accept_scan, i_clk, i_rst_n,
        accept |=> (r_state == kvt_pkg::ST_SCAN && r_addr == '0))
    `KVT_ASSERT(a_full_count, i_clk, i_rst_n,
        (r_state == kvt_pkg::ST_FINISH && r_kind == kvt_pkg::KIND_INSERT
         && !probe.hit && !probe.free) |-> (r_count == CW'(DEPTH)))
    `KVT_ASSERT(a_commit_out, i_clk, i_rst_n,
        commit |=> (r_out_valid && r_state == kvt_pkg::ST_IDLE))

endmodule
